/* src/mfwl_pkg.sv */
`default_nettype none
package mfwl_pkg;

	localparam int unsigned YEAR_W  = 15;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned MDAY_W  = 5;
	localparam int unsigned OFF_W   = 9;
	localparam int unsigned SUM_W   = 16;

	localparam logic [YEAR_W-1:0] YEAR_SWITCH = 15'd1752;
	localparam logic [YEAR_W-1:0] YEAR_MAX    = 15'd29999;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_AUG  = 4'd8;
	localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_OCT  = 4'd10;

	// floor(x / 25) == (x * RECIP_25) >> RECIP_25_SH for x below 2**13.
	localparam logic [13:0] RECIP_25    = 14'd10486;
	localparam int unsigned RECIP_25_SH = 18;
	// floor(x / 7) == (x * RECIP_7) >> RECIP_7_SH for x below 2**16.
	localparam logic [16:0] RECIP_7     = 17'd74899;
	localparam int unsigned RECIP_7_SH  = 19;

	// Day offset of October 1 within the leap year 1752.
	localparam logic [OFF_W-1:0] OCT_1752_OFF = 9'd274;
	// Removes the 1753 epoch: 1753 + G(1752) - 1 Monday offset.
	localparam logic [16:0] GREG_BIAS = 17'd2177;
	localparam logic [16:0] JUL_BIAS  = 17'd6;

	localparam logic [WDAY_W-1:0] GAP_WDAY = 3'd2;
	localparam logic [MDAY_W-1:0] GAP_MDAY = 5'd30;

	typedef struct packed {
		logic bad;
		logic gap;
	} flags_t;

	function automatic logic [OFF_W-1:0] month_offset(
		input logic [MONTH_W-1:0] m,
		input logic               leap
	);
		logic [OFF_W-1:0] off;
		begin
			case (m)
				4'd1:    off = 9'd0;
				4'd2:    off = 9'd31;
				4'd3:    off = 9'd59;
				4'd4:    off = 9'd90;
				4'd5:    off = 9'd120;
				4'd6:    off = 9'd151;
				4'd7:    off = 9'd181;
				4'd8:    off = 9'd212;
				4'd9:    off = 9'd243;
				4'd10:   off = 9'd273;
				4'd11:   off = 9'd304;
				4'd12:   off = 9'd334;
				default: off = 9'd0;
			endcase
			if (m > MONTH_FEB && leap) begin
				off = off + 9'd1;
			end
			return off;
		end
	endfunction

	function automatic logic [MDAY_W-1:0] month_length(
		input logic [MONTH_W-1:0] m,
		input logic               leap
	);
		logic [MDAY_W-1:0] len;
		begin
			case (m)
				4'd2:                   len = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default:                len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage
`default_nettype wire

/* src/month_first_weekday_and_length.sv */
// A query passes the stage 1 to 4 registers in turn to reach the master side.
// Throughput: one year/month query per cycle unless m_tready stalls; stages advance on their own
// ready, so bubbles close up and a full pipeline holds four queries.
// The /25 and /7 steps use reciprocal multipliers, each followed by a register.
// Reset (arst_n low, asynchronous) clears all stage valid bits; no clearing pass.
`default_nettype none
module month_first_weekday_and_length (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [14:0] year_value, [18:15] month_number, [23:19] zero
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [2:0] first_weekday, [7:3] days_in_month
	output logic [7:0]       m_tdata,
	// [0] gap_month, [1] bad_request
	output logic [1:0]       m_tuser
);

	logic [mfwl_pkg::YEAR_W-1:0]  in_year;
	logic [mfwl_pkg::MONTH_W-1:0] in_month;
	logic                         rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic                         v_s1, v_s2, v_s3, v_s4;

	// Stage 1
	mfwl_pkg::flags_t             flags_c1, flags_s1;
	logic [mfwl_pkg::YEAR_W-1:0]  year_s1;
	logic [mfwl_pkg::MONTH_W-1:0] month_s1;
	logic [26:0]                  prod_h_s1;
	logic [24:0]                  prod_f_s1;

	// Stage 2
	logic [8:0]                   h_c2;
	logic [6:0]                   f_c2;
	logic [12:0]                  a_c2;
	logic [13:0]                  h25_c2;
	logic [10:0]                  f25_c2;
	logic                         leap_c2, jul_c2, late_c2, by4_c2, by100_c2, by400_c2;
	logic [mfwl_pkg::OFF_W-1:0]   moff_c2;
	logic [mfwl_pkg::YEAR_W-1:0]  p_c2;
	logic [16:0]                  sum_c2;
	logic [mfwl_pkg::SUM_W-1:0]   sum_s2;
	logic [mfwl_pkg::MDAY_W-1:0]  mday_s2;
	mfwl_pkg::flags_t             flags_s2;

	// Stage 3
	logic [32:0]                  prod7_s3;
	logic [mfwl_pkg::SUM_W-1:0]   sum_s3;
	logic [mfwl_pkg::MDAY_W-1:0]  mday_s3;
	mfwl_pkg::flags_t             flags_s3;

	// Stage 4
	logic [13:0]                  q7_c4;
	logic [mfwl_pkg::SUM_W-1:0]   rem_c4;
	logic [mfwl_pkg::WDAY_W-1:0]  wday_c4, wday_s4;
	logic [mfwl_pkg::MDAY_W-1:0]  mday_c4, mday_s4;
	mfwl_pkg::flags_t             flags_s4;

	assign in_year  = s_tdata[14:0];
	assign in_month = s_tdata[18:15];

	assign rdy_s4   = !v_s4 || m_tready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_comb begin
		flags_c1.bad = (in_year == '0) || (in_year > mfwl_pkg::YEAR_MAX)
			|| !(in_month inside {[4'd1:4'd12]});
		flags_c1.gap = (in_year == mfwl_pkg::YEAR_SWITCH) && (in_month == mfwl_pkg::MONTH_SEP);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			flags_s1  <= flags_c1;
			year_s1   <= in_year;
			month_s1  <= in_month;
			prod_h_s1 <= 27'(in_year[14:2]) * 27'(mfwl_pkg::RECIP_25);
			prod_f_s1 <= 25'(in_year[14:4]) * 25'(mfwl_pkg::RECIP_25);
		end
	end

	always_comb begin
		a_c2      = year_s1[14:2];
		h_c2      = prod_h_s1[26:mfwl_pkg::RECIP_25_SH];
		f_c2      = prod_f_s1[24:mfwl_pkg::RECIP_25_SH];
		h25_c2    = (14'(h_c2) << 4) + (14'(h_c2) << 3) + 14'(h_c2);
		f25_c2    = (11'(f_c2) << 4) + (11'(f_c2) << 3) + 11'(f_c2);
		by4_c2    = (year_s1[1:0] == 2'b00);
		by100_c2  = by4_c2 && (h25_c2 == 14'(a_c2));
		by400_c2  = (year_s1[3:0] == 4'b0000) && (f25_c2 == year_s1[14:4]);
		jul_c2    = (year_s1 < mfwl_pkg::YEAR_SWITCH)
			|| ((year_s1 == mfwl_pkg::YEAR_SWITCH) && (month_s1 <= mfwl_pkg::MONTH_AUG));
		late_c2   = (year_s1 == mfwl_pkg::YEAR_SWITCH) && (month_s1 >= mfwl_pkg::MONTH_OCT);
		if (year_s1 <= mfwl_pkg::YEAR_SWITCH) begin
			leap_c2 = by4_c2;
		end else begin
			leap_c2 = (by4_c2 && !by100_c2) || by400_c2;
		end
		moff_c2 = mfwl_pkg::month_offset(month_s1, leap_c2);
		p_c2    = year_s1 - 15'd1;
		if (jul_c2) begin
			sum_c2 = mfwl_pkg::JUL_BIAS + 17'(p_c2) + 17'(p_c2[14:2]) + 17'(moff_c2);
		end else if (late_c2) begin
			sum_c2 = 17'(moff_c2) - 17'(mfwl_pkg::OCT_1752_OFF);
		end else begin
			sum_c2 = 17'(year_s1) + 17'(a_c2) + 17'(f_c2) + 17'(moff_c2)
				- 17'(h_c2) - 17'(leap_c2) - mfwl_pkg::GREG_BIAS;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			sum_s2   <= sum_c2[mfwl_pkg::SUM_W-1:0];
			mday_s2  <= mfwl_pkg::month_length(month_s1, leap_c2);
			flags_s2 <= flags_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			prod7_s3 <= 33'(sum_s2) * 33'(mfwl_pkg::RECIP_7);
			sum_s3   <= sum_s2;
			mday_s3  <= mday_s2;
			flags_s3 <= flags_s2;
		end
	end

	always_comb begin
		q7_c4  = prod7_s3[32:mfwl_pkg::RECIP_7_SH];
		rem_c4 = sum_s3 - ((16'(q7_c4) << 3) - 16'(q7_c4));
		if (flags_s3.bad) begin
			wday_c4 = '0;
			mday_c4 = '0;
		end else if (flags_s3.gap) begin
			wday_c4 = mfwl_pkg::GAP_WDAY;
			mday_c4 = mfwl_pkg::GAP_MDAY;
		end else begin
			wday_c4 = rem_c4[mfwl_pkg::WDAY_W-1:0];
			mday_c4 = mday_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			wday_s4      <= wday_c4;
			mday_s4      <= mday_c4;
			flags_s4.bad <= flags_s3.bad;
			flags_s4.gap <= flags_s3.gap && !flags_s3.bad;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {mday_s4, wday_s4};
	assign m_tuser  = {flags_s4.bad, flags_s4.gap};

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == 8'd0) && !m_tuser[0])
		else $error("bad request result carries nonzero fields");

	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> (m_tdata[2:0] != 3'd7)
			&& (m_tdata[7:3] >= 5'd28) && (m_tdata[7:3] <= 5'd31))
		else $error("weekday or month length out of range");

	a_gap_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[2:0] == mfwl_pkg::GAP_WDAY)
			&& (m_tdata[7:3] == mfwl_pkg::GAP_MDAY))
		else $error("gap month result is wrong");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transfer did not enter the pipeline");
`endif

endmodule
`default_nettype wire
